[hw/rtl/fraction_sum_reducer_defines.svh]
// Assertion macros used by the checker file fsr_checker.sv.
`ifndef FRACTION_SUM_REDUCER_DEFINES_SVH
`define FRACTION_SUM_REDUCER_DEFINES_SVH

// consequent checked in the same cycle
`define FSR_ASSERT_SAME(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define FSR_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/fsr_pkg.sv]
package fsr_pkg;

    localparam int DIV_W = 64;
    localparam int MUL_W = 32;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_ZERO_DEN = 2'd1;
    localparam status_t STATUS_SAT      = 2'd2;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

endpackage

[hw/rtl/fsr_div.sv]
module fsr_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  fsr_pkg::div_req_t  req,
    output fsr_pkg::div_rsp_t  rsp
);

    localparam int CNT_W = $clog2(fsr_pkg::DIV_W);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [fsr_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [fsr_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [fsr_pkg::DIV_W-1:0] dsr_reg, dsr_next;

    logic [fsr_pkg::DIV_W:0]   shifted;
    logic [fsr_pkg::DIV_W:0]   trial;
    logic                      fits;

    // restoring, one quotient bit a cycle
    assign shifted = {rem_reg, quo_reg[fsr_pkg::DIV_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign fits    = !trial[fsr_pkg::DIV_W];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = fits ? trial[fsr_pkg::DIV_W-1:0] : shifted[fsr_pkg::DIV_W-1:0];
            quo_next = {quo_reg[fsr_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(fsr_pkg::DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

[hw/rtl/fraction_sum_reducer.sv]
// Each accepted word is added to the sum, then reduced by Euclid's loop; a saturating sum needs
// one more division, a zero denominator none. No new word is taken until the last result is written.
// Every remainder and quotient comes from one shared 64-bit radix-2 divider (one bit a cycle);
// the three products share one 32x32 multiplier.
// Reset: synchronous, aresetn low sets the sum to 0/1 and empties the output register.
module fraction_sum_reducer #(
    parameter int IN_WIDTH  = 16,
    parameter int SUM_WIDTH = 32,
    localparam int S_TDATA_W = ((2 * IN_WIDTH + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // add_numerator, add_denominator
    input  logic [0:0]           s_axis_tuser,  // clear_sum
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,  // sum_num_out, sum_den_out
    output logic [1:0]           m_axis_tuser   // status
);

    localparam int SW_EFF = (SUM_WIDTH > 32) ? 32 : SUM_WIDTH;
    localparam logic [fsr_pkg::DIV_W-1:0] NEG_LIM = 64'd1 << (SW_EFF - 1);
    localparam logic [fsr_pkg::DIV_W-1:0] POS_LIM = NEG_LIM - 64'd1;
    localparam int XW = fsr_pkg::MUL_W + 1;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_MUL_AE  = 12'b0000_0000_0010,
        ST_MUL_CD  = 12'b0000_0000_0100,
        ST_MUL_ED  = 12'b0000_0000_1000,
        ST_COMB    = 12'b0000_0001_0000,
        ST_GCD_CHK = 12'b0000_0010_0000,
        ST_GCD_WT  = 12'b0000_0100_0000,
        ST_RED_NUM = 12'b0000_1000_0000,
        ST_RED_DEN = 12'b0001_0000_0000,
        ST_CHECK   = 12'b0010_0000_0000,
        ST_SAT     = 12'b0100_0000_0000,
        ST_WRITE   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0]               sum_num_reg, sum_num_next;
    logic [30:0]               sum_den_reg, sum_den_next;
    logic [fsr_pkg::MUL_W-1:0] mc_reg, mc_next;
    logic [fsr_pkg::MUL_W-1:0] me_reg, me_next;
    logic                      sc_reg, sc_next;
    logic                      zden_reg, zden_next;
    logic                      sat_reg, sat_next;
    logic [fsr_pkg::DIV_W-1:0] mp_reg, mp_next;
    logic [fsr_pkg::DIV_W-1:0] mq_reg, mq_next;
    logic [fsr_pkg::DIV_W-1:0] den_reg, den_next;
    logic [fsr_pkg::DIV_W-1:0] m_reg, m_next;
    logic                      s_reg, s_next;
    logic [fsr_pkg::DIV_W-1:0] x_reg, x_next;
    logic [fsr_pkg::DIV_W-1:0] y_reg, y_next;
    logic                      out_valid_reg, out_valid_next;
    logic [31:0]               out_num_reg, out_num_next;
    logic [30:0]               out_den_reg, out_den_next;
    fsr_pkg::status_t          out_st_reg, out_st_next;

    logic [IN_WIDTH-1:0]       c_in, e_in;
    logic [XW-1:0]             c_ext, e_ext, c_abs, e_abs;
    logic                      accept;
    logic                      sa;
    logic [fsr_pkg::MUL_W-1:0] ma;
    logic [fsr_pkg::MUL_W-1:0] mul_a, mul_b;
    logic [fsr_pkg::DIV_W-1:0] mul_p;
    logic [fsr_pkg::DIV_W-1:0] comb_m;
    logic                      comb_s;
    logic [fsr_pkg::DIV_W-1:0] q_clamp;
    logic                      num_bad;
    logic [31:0]               res_num;
    logic [30:0]               res_den;

    fsr_pkg::div_req_t div_req;
    fsr_pkg::div_rsp_t div_rsp;

    fsr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign c_in  = s_axis_tdata[IN_WIDTH-1:0];
    assign e_in  = s_axis_tdata[2*IN_WIDTH-1:IN_WIDTH];
    assign c_ext = {{(XW - IN_WIDTH){c_in[IN_WIDTH-1]}}, c_in};
    assign e_ext = {{(XW - IN_WIDTH){e_in[IN_WIDTH-1]}}, e_in};
    assign c_abs = c_in[IN_WIDTH-1] ? (XW'(0) - c_ext) : c_ext;
    assign e_abs = e_in[IN_WIDTH-1] ? (XW'(0) - e_ext) : e_ext;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign sa = sum_num_reg[31];
    assign ma = sa ? (32'd0 - sum_num_reg) : sum_num_reg;

    always_comb begin
        mul_a = ma;
        mul_b = me_reg;
        case (state_reg)
            ST_MUL_CD: begin
                mul_a = mc_reg;
                mul_b = {1'b0, sum_den_reg};
            end
            ST_MUL_ED: begin
                mul_a = me_reg;
                mul_b = {1'b0, sum_den_reg};
            end
            default: begin
                mul_a = ma;
                mul_b = me_reg;
            end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    always_comb begin
        if (sa == sc_reg) begin
            comb_m = mp_reg + mq_reg;
            comb_s = sa;
        end else if (mp_reg >= mq_reg) begin
            comb_m = mp_reg - mq_reg;
            comb_s = sa;
        end else begin
            comb_m = mq_reg - mp_reg;
            comb_s = sc_reg;
        end
    end

    assign num_bad = s_reg ? (m_reg > NEG_LIM) : (m_reg > POS_LIM);

    always_comb begin
        q_clamp = div_rsp.quotient;
        if (s_reg && q_clamp > NEG_LIM) begin
            q_clamp = NEG_LIM;
        end
        if (!s_reg && q_clamp > POS_LIM) begin
            q_clamp = POS_LIM;
        end
    end

    assign res_num = zden_reg ? sum_num_reg
                   : (s_reg ? (32'd0 - m_reg[31:0]) : m_reg[31:0]);
    assign res_den = zden_reg ? sum_den_reg : den_reg[30:0];

    always_comb begin
        state_next     = state_reg;
        sum_num_next   = sum_num_reg;
        sum_den_next   = sum_den_reg;
        mc_next        = mc_reg;
        me_next        = me_reg;
        sc_next        = sc_reg;
        zden_next      = zden_reg;
        sat_next       = sat_reg;
        mp_next        = mp_reg;
        mq_next        = mq_reg;
        den_next       = den_reg;
        m_next         = m_reg;
        s_next         = s_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        out_valid_next = out_valid_reg;
        out_num_next   = out_num_reg;
        out_den_next   = out_den_reg;
        out_st_next    = out_st_reg;
        div_req        = '0;

        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_axis_tuser[0]) begin
                        sum_num_next = '0;
                        sum_den_next = 31'd1;
                    end
                    mc_next    = c_abs[fsr_pkg::MUL_W-1:0];
                    me_next    = e_abs[fsr_pkg::MUL_W-1:0];
                    sc_next    = c_in[IN_WIDTH-1] ^ e_in[IN_WIDTH-1];
                    zden_next  = (e_in == '0);
                    sat_next   = 1'b0;
                    state_next = (e_in == '0) ? ST_WRITE : ST_MUL_AE;
                end
            end
            ST_MUL_AE: begin
                mp_next    = mul_p;
                state_next = ST_MUL_CD;
            end
            ST_MUL_CD: begin
                mq_next    = mul_p;
                state_next = ST_MUL_ED;
            end
            ST_MUL_ED: begin
                den_next   = mul_p;
                state_next = ST_COMB;
            end
            ST_COMB: begin
                m_next     = comb_m;
                s_next     = comb_s && (comb_m != '0);
                x_next     = comb_m;
                y_next     = den_reg;
                state_next = ST_GCD_CHK;
            end
            ST_GCD_CHK: begin
                div_req.start = 1'b1;
                if (y_reg != '0) begin
                    div_req.dividend = x_reg;
                    div_req.divisor  = y_reg;
                    state_next       = ST_GCD_WT;
                end else begin
                    // x holds the gcd
                    div_req.dividend = m_reg;
                    div_req.divisor  = x_reg;
                    state_next       = ST_RED_NUM;
                end
            end
            ST_GCD_WT: begin
                if (div_rsp.done) begin
                    x_next     = y_reg;
                    y_next     = div_rsp.remainder;
                    state_next = ST_GCD_CHK;
                end
            end
            ST_RED_NUM: begin
                if (div_rsp.done) begin
                    m_next           = div_rsp.quotient;
                    div_req.start    = 1'b1;
                    div_req.dividend = den_reg;
                    div_req.divisor  = x_reg;
                    state_next       = ST_RED_DEN;
                end
            end
            ST_RED_DEN: begin
                if (div_rsp.done) begin
                    den_next   = div_rsp.quotient;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (num_bad || den_reg > POS_LIM) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = m_reg;
                    div_req.divisor  = den_reg;
                    state_next       = ST_SAT;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_SAT: begin
                if (div_rsp.done) begin
                    m_next     = q_clamp;
                    s_next     = s_reg && (q_clamp != '0);
                    den_next   = 64'd1;
                    sat_next   = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (!out_valid_reg || m_axis_tready) begin
                    sum_num_next   = res_num;
                    sum_den_next   = res_den;
                    out_num_next   = res_num;
                    out_den_next   = res_den;
                    out_st_next    = zden_reg ? fsr_pkg::STATUS_ZERO_DEN
                                   : (sat_reg ? fsr_pkg::STATUS_SAT : fsr_pkg::STATUS_OK);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sum_num_reg   <= '0;
            sum_den_reg   <= 31'd1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sum_num_reg   <= sum_num_next;
            sum_den_reg   <= sum_den_next;
            out_valid_reg <= out_valid_next;
        end
        mc_reg      <= mc_next;
        me_reg      <= me_next;
        sc_reg      <= sc_next;
        zden_reg    <= zden_next;
        sat_reg     <= sat_next;
        mp_reg      <= mp_next;
        mq_reg      <= mq_next;
        den_reg     <= den_next;
        m_reg       <= m_next;
        s_reg       <= s_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        out_num_reg <= out_num_next;
        out_den_reg <= out_den_next;
        out_st_reg  <= out_st_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_den_reg, out_num_reg};
    assign m_axis_tuser  = out_st_reg;

endmodule

[hw/rtl/fsr_checker.sv]
`include "fraction_sum_reducer_defines.svh"

module fsr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    `FSR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word lost or changed while stalled")

    `FSR_ASSERT_NEXT(a_one_word, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word taken before the first is done")

    `FSR_ASSERT_SAME(a_den_pos, m_axis_tvalid, m_axis_tdata[62:32] != 31'd0, "zero denominator on output")

    `FSR_ASSERT_SAME(a_sat_whole, m_axis_tvalid && m_axis_tuser == fsr_pkg::STATUS_SAT, m_axis_tdata[62:32] == 31'd1, "saturated sum not a whole number")

endmodule

bind fraction_sum_reducer fsr_checker u_fsr_checker (.*);
